// ----- rtl/core/two_level_feedback_scheduler_macros.svh -----
// Assertion macros shared by the scheduler modules.
`ifndef TWO_LEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
`define TWO_LEVEL_FEEDBACK_SCHEDULER_MACROS_SVH

// Checked on clk, off while rst is high.
`define TFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define TFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/tfs_pkg.sv -----
// Shared types and constants of the two-level feedback scheduler.
package tfs_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int PID_W           = 32;
  localparam int QUANTUM_W       = 16;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd100;

  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_LEAVE    = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SRC_NEW       = 2'd0,
    SRC_UNBLOCKED = 2'd1,
    SRC_PREEMPTED = 2'd2,
    SRC_INVALID   = 2'd3
  } src_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic finish;   // queue read data is ready, load the dispatch result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_valid;   // result register holds a word
    logic pop_needed;  // word at the input is a dispatch that pops a queue
  } dp_status_t;

  typedef struct packed {
    logic             bad_source;
    logic             queue_full;
    logic [PID_W-1:0] interrupt_pid;
    logic             interrupt_valid;
    logic             none_ready;
    logic             dispatch_from_rr;
    logic [PID_W-1:0] dispatch_pid;
    logic             dispatch_valid;
  } result_t;

endpackage

// ----- rtl/core/two_level_feedback_scheduler.sv -----
// Two-level feedback scheduler: round-robin and FIFO process queues with quantum timer.
//
// Input channel s_axis: one word per operation. tuser carries operation and
// source, tdata the process id (used by enqueue only). Output channel m_axis:
// exactly one result word per input word, in order. tuser holds the status
// flags, tdata the dispatched id (low half) and the preempted id (high half).
// cfg_we/cfg_data load the quantum length in ticks (reset value 100); write
// only while no word is in flight.
//
// Enqueue, leave, tick and an empty dispatch show their result in the cycle
// after acceptance. A dispatch that pops a queue goes through the registered
// read port of the queue memory and then the result register; the input is
// held off during the read. Throughput: one word per cycle while m_axis takes
// results; a popping dispatch holds off the next word while its read is under way.
//
// Reset empties both queues (head and count cleared, no memory sweep),
// disarms the timer and restores the quantum register. When m_axis stalls,
// the result register holds its word and s_axis_tready drops until the word
// is taken; a new word is accepted in the same cycle the old one leaves.
module two_level_feedback_scheduler
  import tfs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [QUANTUM_W-1:0]   cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [PID_W-1:0]       s_axis_tdata,   // pid
  input  logic [3:0]             s_axis_tuser,   // operation[1:0], source[3:2]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [2*PID_W-1:0]     m_axis_tdata,   // dispatch_pid, interrupt_pid
  output logic [5:0]             m_axis_tuser    // dispatch_valid, dispatch_from_rr,
                                                 // none_ready, interrupt_valid,
                                                 // queue_full, bad_source
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    res;

  tfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .res_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tfs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_op     (op_t'(s_axis_tuser[1:0])),
    .in_src    (src_t'(s_axis_tuser[3:2])),
    .in_pid    (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .res_ready (m_axis_tready),
    .res_valid (m_axis_tvalid),
    .res       (res)
  );

  assign m_axis_tdata = {res.interrupt_pid, res.dispatch_pid};
  assign m_axis_tuser = {res.bad_source, res.queue_full, res.interrupt_valid,
                         res.none_ready, res.dispatch_from_rr, res.dispatch_valid};

endmodule

// ----- rtl/core/tfs_queue.sv -----
// Circular process-id queue with a registered read port.
module tfs_queue
  import tfs_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             pop,
  input  logic [PID_W-1:0] wdata,
  output logic [PID_W-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [PID_W-1:0] mem [DEPTH];
  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [SW-1:0]    tail_sum;
  logic [AW-1:0]    tail;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  // head + count stays below twice the depth, so one subtract wraps it
  assign tail_sum = SW'(head) + SW'(count);
  always_comb begin
    if (tail_sum >= SW'(DEPTH)) begin
      tail = AW'(tail_sum - SW'(DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wdata;
    end
    if (pop) begin
      rdata <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head  <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
        count <= count - CW'(1);
      end else if (push) begin
        count <= count + CW'(1);
      end
    end
  end

`include "two_level_feedback_scheduler_macros.svh"

  `TFS_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
  `TFS_ASSERT(a_no_pop_empty, pop |-> !empty, "pop from empty queue")
  `TFS_ASSERT(a_push_grows, (push && !pop) |=> (count == $past(count) + CW'(1)), "count lost a push")

endmodule

// ----- rtl/core/tfs_datapath.sv -----
// Scheduler datapath: both queues, quantum timer and the result register.
module tfs_datapath
  import tfs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [QUANTUM_W-1:0] cfg_data,
  input  op_t                  in_op,
  input  src_t                 in_src,
  input  logic [PID_W-1:0]     in_pid,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  logic                 res_ready,
  output logic                 res_valid,
  output result_t              res
);

  logic [QUANTUM_W-1:0] quantum_ticks;
  logic [QUANTUM_W-1:0] quantum_left;
  logic                 timer_armed;
  logic [PID_W-1:0]     timer_pid;
  logic                 running_from_rr;
  logic                 pend_rr;

  logic             rr_push, rr_pop, rr_empty, rr_full;
  logic             fifo_push, fifo_pop, fifo_empty, fifo_full;
  logic [PID_W-1:0] rr_rdata, fifo_rdata;
  logic             to_rr, to_fifo;
  logic             load_now;
  result_t          res_imm;

  assign to_rr   = (in_op == OP_ENQUEUE) && (in_src inside {SRC_NEW, SRC_UNBLOCKED});
  assign to_fifo = (in_op == OP_ENQUEUE) && (in_src == SRC_PREEMPTED);

  assign rr_push   = cmd.accept && to_rr && !rr_full;
  assign fifo_push = cmd.accept && to_fifo && !fifo_full;
  assign rr_pop    = cmd.accept && (in_op == OP_DISPATCH) && !rr_empty;
  assign fifo_pop  = cmd.accept && (in_op == OP_DISPATCH) && rr_empty && !fifo_empty;

  assign status.pop_needed = (in_op == OP_DISPATCH) && !(rr_empty && fifo_empty);
  assign status.out_valid  = res_valid;
  assign load_now          = cmd.accept && !status.pop_needed;

  tfs_queue #(.DEPTH(QUEUE_DEPTH)) u_rr (
    .clk   (clk),
    .rst   (rst),
    .push  (rr_push),
    .pop   (rr_pop),
    .wdata (in_pid),
    .rdata (rr_rdata),
    .empty (rr_empty),
    .full  (rr_full)
  );

  tfs_queue #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fifo_push),
    .pop   (fifo_pop),
    .wdata (in_pid),
    .rdata (fifo_rdata),
    .empty (fifo_empty),
    .full  (fifo_full)
  );

  // result of every word that needs no queue read
  always_comb begin
    res_imm = '0;
    case (in_op)
      OP_ENQUEUE: begin
        if (in_src == SRC_INVALID) begin
          res_imm.bad_source = 1'b1;
        end else if ((to_rr && rr_full) || (to_fifo && fifo_full)) begin
          res_imm.queue_full = 1'b1;
        end
      end
      OP_DISPATCH: begin
        res_imm.none_ready = 1'b1;
      end
      OP_TICK: begin
        if (timer_armed && (quantum_left <= QUANTUM_W'(1))) begin
          res_imm.interrupt_valid = 1'b1;
          res_imm.interrupt_pid   = timer_pid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_ticks   <= QUANTUM_RESET;
      quantum_left    <= '0;
      timer_armed     <= 1'b0;
      timer_pid       <= '0;
      running_from_rr <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum_ticks <= cfg_data;
      end
      if (load_now || cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (cmd.finish && pend_rr) begin
        timer_pid <= rr_rdata;
      end
      if (cmd.accept) begin
        case (in_op)
          OP_DISPATCH: begin
            running_from_rr <= !rr_empty;
            if (!rr_empty) begin
              quantum_left <= quantum_ticks;
              timer_armed  <= 1'b1;
            end
          end
          OP_LEAVE: begin
            if (running_from_rr) begin
              timer_armed  <= 1'b0;
              quantum_left <= '0;
            end
          end
          OP_TICK: begin
            if (timer_armed) begin
              if (quantum_left <= QUANTUM_W'(1)) begin
                quantum_left <= '0;
                timer_armed  <= 1'b0;
              end else begin
                quantum_left <= quantum_left - QUANTUM_W'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rr_pop || fifo_pop) begin
      pend_rr <= rr_pop;
    end
    if (load_now) begin
      res <= res_imm;
    end else if (cmd.finish) begin
      res <= '{dispatch_valid: 1'b1, dispatch_from_rr: pend_rr,
               dispatch_pid: pend_rr ? rr_rdata : fifo_rdata, default: '0};
    end
  end

endmodule

// ----- rtl/core/tfs_ctrl.sv -----
// Scheduler controller: input handshake and the queue-read wait state.
module tfs_ctrl
  import tfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       res_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  state_t state;

  // result register is free, or drains this cycle
  assign in_ready   = (state == ST_IDLE) && (!status.out_valid || res_ready);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.finish = (state == ST_FETCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.accept && status.pop_needed) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "two_level_feedback_scheduler_macros.svh"

  `TFS_ASSERT(a_fetch_one_cycle, (state == ST_FETCH) |=> (state == ST_IDLE), "fetch state held")
  `TFS_ASSERT(a_fetch_no_accept, (state == ST_FETCH) |-> !cmd.accept, "word taken during fetch")
  `TFS_ASSERT(a_no_overwrite, (status.out_valid && !res_ready) |-> !cmd.accept, "result overwritten")
  `TFS_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE), "controller not idle after reset")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the two-level feedback scheduler: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;
  import tfs_pkg::*;

  localparam int DEPTH      = DEF_QUEUE_DEPTH;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 115;

  typedef enum int {MIX, FILL, DRAIN, TIMED} traffic_t;

  // one row of the directed table; fixed rows carry a hand-typed result
  typedef struct packed {
    logic                 load;   // write quantum before this row
    logic [QUANTUM_W-1:0] quantum;
    op_t                  op;
    src_t                 src;
    logic [PID_W-1:0]     pid;
    logic                 fixed;
    result_t              want;
  } row_t;

  localparam result_t R_IDLE   = '0;
  localparam result_t R_EMPTY  = '{none_ready: 1'b1, default: '0};
  localparam result_t R_BADSRC = '{bad_source: 1'b1, default: '0};
  localparam result_t R_RR0    = '{dispatch_valid: 1'b1, dispatch_from_rr: 1'b1, default: '0};

  localparam int PLAN_LEN = 27;
  localparam row_t PLAN [PLAN_LEN] = '{
    '{1'b0, 16'd0,     OP_DISPATCH, SRC_NEW,       32'h0000_0000, 1'b1, R_EMPTY},
    '{1'b0, 16'd0,     OP_TICK,     SRC_INVALID,   32'hFFFF_FFFF, 1'b1, R_IDLE},
    '{1'b0, 16'd0,     OP_LEAVE,    SRC_PREEMPTED, 32'h0000_0000, 1'b1, R_IDLE},
    '{1'b0, 16'd0,     OP_ENQUEUE,  SRC_INVALID,   32'hFFFF_FFFF, 1'b1, R_BADSRC},
    '{1'b0, 16'd0,     OP_ENQUEUE,  SRC_NEW,       32'h0000_0000, 1'b1, R_IDLE},
    '{1'b0, 16'd0,     OP_ENQUEUE,  SRC_UNBLOCKED, 32'hFFFF_FFFF, 1'b1, R_IDLE},
    '{1'b0, 16'd0,     OP_ENQUEUE,  SRC_PREEMPTED, 32'h1234_5678, 1'b1, R_IDLE},
    '{1'b0, 16'd0,     OP_ENQUEUE,  SRC_PREEMPTED, 32'hFFFF_FFFF, 1'b1, R_IDLE},
    '{1'b0, 16'd0,     OP_DISPATCH, SRC_INVALID,   32'hFFFF_FFFF, 1'b1, R_RR0},
    '{1'b0, 16'd0,     OP_TICK,     SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_LEAVE,    SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_TICK,     SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_DISPATCH, SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    // FIFO dispatch with the timer still armed, then a leave that must not disarm
    '{1'b0, 16'd0,     OP_DISPATCH, SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_LEAVE,    SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b1, 16'd1,     OP_ENQUEUE,  SRC_NEW,       32'hA5A5_A5A5, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_DISPATCH, SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_TICK,     SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_TICK,     SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_DISPATCH, SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_DISPATCH, SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    // zero quantum, and a round-robin dispatch that reloads an armed timer
    '{1'b1, 16'd0,     OP_ENQUEUE,  SRC_UNBLOCKED, 32'h0000_FFFF, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_ENQUEUE,  SRC_NEW,       32'hFFFF_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_DISPATCH, SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_DISPATCH, SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_TICK,     SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE},
    '{1'b0, 16'd0,     OP_LEAVE,    SRC_NEW,       32'h0000_0000, 1'b0, R_IDLE}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [QUANTUM_W-1:0] cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PID_W-1:0]     s_axis_tdata = '0;
  logic [3:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*PID_W-1:0]   m_axis_tdata;
  logic [5:0]           m_axis_tuser;

  // predictor state
  logic [PID_W-1:0]     hi_q [DEPTH];
  logic [PID_W-1:0]     lo_q [DEPTH];
  int                   hi_head = 0, hi_cnt = 0, lo_head = 0, lo_cnt = 0;
  logic [QUANTUM_W-1:0] slice_len = QUANTUM_RESET;
  logic [QUANTUM_W-1:0] slice_left = '0;
  logic                 armed = 1'b0;
  logic [PID_W-1:0]     armed_pid = '0;
  logic                 on_rr = 1'b0;

  result_t pending_results [$];
  int      mismatch_count = 0;
  int      quiet = 0;
  bit      calm = 1'b0;

  two_level_feedback_scheduler dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // next scheduler result, advancing the predictor state
  function automatic result_t schedule_step(input op_t op, input src_t src,
                                            input logic [PID_W-1:0] pid);
    result_t r;
    r = '0;
    case (op)
      OP_ENQUEUE: begin
        if (src == SRC_INVALID) begin
          r.bad_source = 1'b1;
        end else if (src == SRC_PREEMPTED) begin
          if (lo_cnt >= DEPTH) r.queue_full = 1'b1;
          else begin
            lo_q[(lo_head + lo_cnt) % DEPTH] = pid;
            lo_cnt++;
          end
        end else begin
          if (hi_cnt >= DEPTH) r.queue_full = 1'b1;
          else begin
            hi_q[(hi_head + hi_cnt) % DEPTH] = pid;
            hi_cnt++;
          end
        end
      end
      OP_DISPATCH: begin
        if (hi_cnt != 0) begin
          r.dispatch_valid   = 1'b1;
          r.dispatch_pid     = hi_q[hi_head];
          r.dispatch_from_rr = 1'b1;
          hi_head    = (hi_head + 1) % DEPTH;
          hi_cnt--;
          slice_left = slice_len;
          armed      = 1'b1;
          armed_pid  = r.dispatch_pid;
          on_rr      = 1'b1;
        end else if (lo_cnt != 0) begin
          r.dispatch_valid = 1'b1;
          r.dispatch_pid   = lo_q[lo_head];
          lo_head = (lo_head + 1) % DEPTH;
          lo_cnt--;
          on_rr   = 1'b0;
        end else begin
          r.none_ready = 1'b1;
          on_rr        = 1'b0;
        end
      end
      OP_LEAVE: begin
        if (on_rr) begin
          armed      = 1'b0;
          slice_left = '0;
        end
      end
      default: begin
        if (armed) begin
          if (slice_left <= 1) begin
            slice_left        = '0;
            armed             = 1'b0;
            r.interrupt_valid = 1'b1;
            r.interrupt_pid   = armed_pid;
          end else begin
            slice_left = slice_left - 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input op_t op, input src_t src, input logic [PID_W-1:0] pid,
                           input logic fixed, input result_t want);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {src, op};
    s_axis_tdata  <= pid;
    do @(posedge clk); while (!s_axis_tready);
    predicted = schedule_step(op, src, pid);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  // quantum is only rewritten with nothing in flight
  task automatic load_quantum(input logic [QUANTUM_W-1:0] q);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= q;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slice_len = q;
  endtask

  task automatic check_field(input string name, input logic [PID_W-1:0] want,
                             input logic [PID_W-1:0] seen);
    if (want !== seen) begin
      $display("%0t %s mismatch: expected %h, got %h", $time, name, want, seen);
      mismatch_count++;
    end
  endtask

  // output side: random backpressure
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word: tuser %h tdata %h", $time, m_axis_tuser,
                 m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("dispatch_valid",   want.dispatch_valid,   m_axis_tuser[0]);
        check_field("dispatch_from_rr", want.dispatch_from_rr, m_axis_tuser[1]);
        check_field("none_ready",       want.none_ready,       m_axis_tuser[2]);
        check_field("interrupt_valid",  want.interrupt_valid,  m_axis_tuser[3]);
        check_field("queue_full",       want.queue_full,       m_axis_tuser[4]);
        check_field("bad_source",       want.bad_source,       m_axis_tuser[5]);
        check_field("dispatch_pid",     want.dispatch_pid,     m_axis_tdata[PID_W-1:0]);
        check_field("interrupt_pid",    want.interrupt_pid,    m_axis_tdata[2*PID_W-1:PID_W]);
      end
    end
  end

  // watchdog: too long without a word on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    traffic_t             mode;
    int                   run, r;
    logic [QUANTUM_W-1:0] q;
    op_t                  op;
    src_t                 src, fill_src;
    logic [PID_W-1:0]     pid;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].load) load_quantum(PLAN[i].quantum);
      send_word(PLAN[i].op, PLAN[i].src, PLAN[i].pid, PLAN[i].fixed, PLAN[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: q = 16'd1;
        1: q = 16'hFFFF;
        2: q = 16'd0;
        3: q = 16'd3;
        4: q = 16'($urandom_range(2, 12));
        5: q = 16'($urandom_range(1, 65535));
        6: q = 16'($urandom_range(1, 30));
        default: q = 16'd1;
      endcase
      load_quantum(q);
      for (int n = 0; n < PHASE_LEN; ) begin
        mode     = traffic_t'($urandom_range(0, 3));
        calm     = ($urandom_range(0, 4) == 0);
        run      = (mode == FILL) ? 90 : $urandom_range(15, 50);
        fill_src = src_t'($urandom_range(0, 2));
        if (run > PHASE_LEN - n) run = PHASE_LEN - n;
        repeat (run) begin
          r = $urandom_range(0, 99);
          case (mode)
            FILL:    op = (r < 80) ? OP_ENQUEUE : (r < 85) ? OP_DISPATCH :
                          (r < 90) ? OP_LEAVE : OP_TICK;
            DRAIN:   op = (r < 10) ? OP_ENQUEUE : (r < 70) ? OP_DISPATCH :
                          (r < 80) ? OP_LEAVE : OP_TICK;
            TIMED:   op = (r < 10) ? OP_ENQUEUE : (r < 25) ? OP_DISPATCH :
                          (r < 35) ? OP_LEAVE : OP_TICK;
            default: op = (r < 35) ? OP_ENQUEUE : (r < 60) ? OP_DISPATCH :
                          (r < 70) ? OP_LEAVE : OP_TICK;
          endcase
          r = $urandom_range(0, 99);
          if (mode == FILL && r < 85) src = fill_src;
          else if (r < 91) src = src_t'($urandom_range(0, 2));
          else src = SRC_INVALID;
          r = $urandom_range(0, 15);
          pid = (r == 0) ? '0 : (r == 1) ? '1 : PID_W'($urandom());
          send_word(op, src, pid, 1'b0, R_IDLE);
          n++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
